FILE: rtl/acmv_pkg.sv
// shared types, constants and aes round functions for the cbc-mac checker
`default_nettype none
package acmv_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned BlockBits  = 128;
  localparam int unsigned MacBits    = 32;
  localparam int unsigned LastRound  = 10;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    REG_MAC1_HI = 3'd0,
    REG_MAC1_LO = 3'd1,
    REG_MAC2_HI = 3'd2,
    REG_MAC2_LO = 3'd3,
    REG_SEED_HI = 3'd4,
    REG_SEED_LO = 3'd5
  } reg_idx_e;

  typedef logic [BlockBits-1:0] block_t;

  // one block of work for the cipher side
  typedef struct packed {
    block_t              blk;
    logic                first;
    logic                last;
    logic [MacBits-1:0]  rmac;
  } job_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon_of(input logic [3:0] rnd);
    logic [7:0] rc;
    case (rnd)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 sits in the top bits
  function automatic logic [7:0] byte_of(input block_t b, input int unsigned i);
    return b[BlockBits-1-8*i -: 8];
  endfunction

  function automatic block_t key_next(input block_t rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tmp;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ tmp;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic block_t aes_round(input block_t s, input block_t rk, input logic fin);
    logic [7:0] t [0:15];
    logic [7:0] m [0:15];
    logic [7:0] all;
    block_t     r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4+i] = SBOX[byte_of(s, ((c + i) % 4) * 4 + i)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
      m[c*4]   = t[c*4]   ^ all ^ xtime(t[c*4]   ^ t[c*4+1]);
      m[c*4+1] = t[c*4+1] ^ all ^ xtime(t[c*4+1] ^ t[c*4+2]);
      m[c*4+2] = t[c*4+2] ^ all ^ xtime(t[c*4+2] ^ t[c*4+3]);
      m[c*4+3] = t[c*4+3] ^ all ^ xtime(t[c*4+3] ^ t[c*4]);
    end
    for (int i = 0; i < 16; i++) begin
      r[BlockBits-1-8*i -: 8] = (fin ? t[i] : m[i]) ^ byte_of(rk, i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/acmv_front.sv
// byte gatherer: builds blocks and hands block jobs to the queue
`default_nettype none
module acmv_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 take_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 is_last_i,
  input  wire logic [31:0]          received_mac_i,
  output acmv_pkg::job_t            job_a_o,
  output logic                      push_a_o,
  output acmv_pkg::job_t            job_b_o,
  output logic                      push_b_o
);
  import acmv_pkg::*;

  block_t     gather_q, gather_d;
  logic [3:0] cnt_q, cnt_d;
  logic       active_q, active_d;
  logic       first_q, first_d;

  logic       push_held;
  logic [3:0] idx;
  block_t     base, new_blk;
  job_t       held_job, last_job;

  always_comb begin
    push_held = active_q && (cnt_q == 4'd0);
    idx       = active_q ? cnt_q : 4'd0;
    base      = (!active_q || push_held) ? '0 : gather_q;
    new_blk   = base | ({data_byte_i, {(BlockBits-8){1'b0}}} >> {idx, 3'b000});

    held_job.blk   = gather_q;
    held_job.first = first_q;
    held_job.last  = 1'b0;
    held_job.rmac  = '0;

    last_job.blk   = new_blk;
    last_job.first = !active_q || (!push_held && first_q);
    last_job.last  = 1'b1;
    last_job.rmac  = received_mac_i;

    job_a_o  = push_held ? held_job : last_job;
    job_b_o  = last_job;
    push_a_o = take_i && (push_held || is_last_i);
    push_b_o = take_i && push_held && is_last_i;

    gather_d = gather_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    first_d  = first_q;
    if (take_i) begin
      if (is_last_i) begin
        active_d = 1'b0;
        cnt_d    = 4'd0;
      end else begin
        active_d = 1'b1;
        cnt_d    = idx + 4'd1;
        gather_d = new_blk;
        first_d  = !active_q || (!push_held && first_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 4'd0;
      active_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      active_q <= active_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gather_q <= gather_d;
  end

endmodule
`default_nettype wire

FILE: rtl/acmv_jobq.sv
// short job queue, up to two pushes and one pop per cycle
`default_nettype none
module acmv_jobq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire acmv_pkg::job_t            job_a_i,
  input  wire logic                      push_a_i,
  input  wire acmv_pkg::job_t            job_b_i,
  input  wire logic                      push_b_i,
  input  wire logic                      pop_i,
  output acmv_pkg::job_t                 head_o,
  output logic                           head_valid_o,
  output logic                           room2_o,
  output logic [acmv_pkg::QCntW-1:0]     count_o
);
  import acmv_pkg::*;

  job_t              mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic [QPtrW-1:0]  wr_b;

  always_comb begin
    wr_b  = wr_q + QPtrW'(1);
    cnt_d = cnt_q + QCntW'(push_a_i) + QCntW'(push_b_i) - QCntW'(pop_i);
  end

  assign head_o       = mem_q[rd_q];
  assign head_valid_o = (cnt_q != '0);
  assign room2_o      = (cnt_q <= QCntW'(QueueDepth - 2));
  assign count_o      = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_a_i) + QPtrW'(push_b_i);
      rd_q  <= rd_q + QPtrW'(pop_i);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_q] <= job_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_b] <= job_b_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/acmv_back.sv
// cbc chaining and iterated aes-128, one round per cycle, result register
`default_nettype none
module acmv_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire acmv_pkg::job_t        head_i,
  input  wire logic                  head_valid_i,
  output logic                       pop_o,
  input  wire acmv_pkg::block_t      key1_i,
  input  wire acmv_pkg::block_t      key2_i,
  input  wire acmv_pkg::block_t      seed_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       mac_ok_o,
  output logic [31:0]                computed_mac_o
);
  import acmv_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_e;

  state_e      state_q;
  block_t      st_q, rk_q, chain_q;
  logic [3:0]  rnd_q;
  logic        last_q;
  logic [31:0] rmac_q;
  logic        ov_q, ok_q;
  logic        ov_d;
  logic [31:0] mac_q;

  block_t      rk_n, ch_in, key_sel;
  logic        slot_free;

  always_comb begin
    rk_n      = key_next(rk_q, rcon_of(rnd_q));
    ch_in     = head_i.first ? seed_i : chain_q;
    key_sel   = head_i.last ? key2_i : key1_i;
    pop_o     = (state_q == ST_IDLE) && head_valid_i;
    slot_free = !ov_q || !out_stall_i;
    ov_d      = ov_q && out_stall_i;
    if ((state_q == ST_DONE) && last_q && slot_free) begin
      ov_d = 1'b1;
    end
  end

  assign out_valid_o    = ov_q;
  assign mac_ok_o       = ok_q;
  assign computed_mac_o = mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      rnd_q   <= 4'd0;
      last_q  <= 1'b0;
    end else begin
      ov_q <= ov_d;
      case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            st_q    <= ch_in ^ head_i.blk ^ key_sel;
            rk_q    <= key_sel;
            rnd_q   <= 4'd1;
            last_q  <= head_i.last;
            rmac_q  <= head_i.rmac;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          st_q  <= aes_round(st_q, rk_n, rnd_q == 4'(LastRound));
          rk_q  <= rk_n;
          rnd_q <= rnd_q + 4'd1;
          if (rnd_q == 4'(LastRound)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!last_q) begin
            chain_q <= st_q;
            state_q <= ST_IDLE;
          end else if (slot_free) begin
            mac_q   <= st_q[BlockBits-1 -: MacBits];
            ok_q    <= (st_q[BlockBits-1 -: MacBits] == rmac_q);
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/aes_cbc_mac_verify.sv
// top level of the two-key aes-128 cbc-mac checker
//
//   channel   direction  signals                                   moves
//   in        input      in_valid_i / in_stall_o, data, last, mac  one message byte
//   out       output     out_valid_o / out_stall_i, ok, mac        one check result
//   cfg       input      cfg_we_i, cfg_index_i, cfg_data_i         one key or seed word
//
// bytes are taken one per cycle while in_stall_o is low; the front gathers them into 16-byte blocks
// each block goes through the back in order: load, ten aes rounds, retire
// in_stall_o rises only when the job queue has fewer than two free slots,
// so long messages run at one byte per cycle while the back keeps pace, short ones at the pace of the back
// reset clears all control state and the key and seed registers
// the result register frees the cipher while a result waits to be taken
`default_nettype none
module aes_cbc_mac_verify (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        is_last_i,
  input  wire logic [31:0] received_mac_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             mac_ok_o,
  output logic [31:0]      computed_mac_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  import acmv_pkg::*;

  // key and seed registers
  logic [63:0] mac1_hi_q, mac1_lo_q, mac2_hi_q, mac2_lo_q, seed_hi_q, seed_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac1_hi_q <= '0;
      mac1_lo_q <= '0;
      mac2_hi_q <= '0;
      mac2_lo_q <= '0;
      seed_hi_q <= '0;
      seed_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAC1_HI: mac1_hi_q <= cfg_data_i;
        REG_MAC1_LO: mac1_lo_q <= cfg_data_i;
        REG_MAC2_HI: mac2_hi_q <= cfg_data_i;
        REG_MAC2_LO: mac2_lo_q <= cfg_data_i;
        REG_SEED_HI: seed_hi_q <= cfg_data_i;
        REG_SEED_LO: seed_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  job_t              job_a, job_b, head;
  logic              push_a, push_b, head_valid, room2, pop;
  logic [QCntW-1:0]  q_count;
  logic              take;

  // a request is taken when valid and the queue can hold two jobs
  assign in_stall_o = !room2;
  assign take       = in_valid_i && room2;

  acmv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .data_byte_i    (data_byte_i),
    .is_last_i      (is_last_i),
    .received_mac_i (received_mac_i),
    .job_a_o        (job_a),
    .push_a_o       (push_a),
    .job_b_o        (job_b),
    .push_b_o       (push_b)
  );

  acmv_jobq u_jobq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_a_i      (job_a),
    .push_a_i     (push_a),
    .job_b_i      (job_b),
    .push_b_i     (push_b),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .room2_o      (room2),
    .count_o      (q_count)
  );

  acmv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .key1_i         ({mac1_hi_q, mac1_lo_q}),
    .key2_i         ({mac2_hi_q, mac2_lo_q}),
    .seed_i         ({seed_hi_q, seed_lo_q}),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mac_ok_o       (mac_ok_o),
    .computed_mac_o (computed_mac_o)
  );

`ifndef SYNTHESIS
  // queue never holds more jobs than it has slots
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCntW'(QueueDepth))
    else $error("job queue overflow");

  // the back only pops a job that is there
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty job queue");

  // a second push in one cycle only comes with a first
  a_push_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_b |-> (push_a && take))
    else $error("lone second job push");
`endif

endmodule
`default_nettype wire
